// ===== hw/rtl/icy_metadata_deframer_defines.svh =====
// Assertion macros used by the ICY metadata deframer RTL.
`ifndef ICY_METADATA_DEFRAMER_DEFINES_SVH
`define ICY_METADATA_DEFRAMER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define ICY_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icy deframer: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ICY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icy deframer: next-cycle check failed");

`endif

// ===== hw/rtl/icy_pkg.sv =====
// Types and constants for the ICY metadata deframer.
package icy_pkg;

    localparam int DATA_W     = 8;
    localparam int KIND_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int LEN_W      = 12;
    localparam int UNIT_SHIFT = 4;   // length byte counts 16-byte units

    localparam int PADDR_W  = 3;
    localparam int ADDR_LSB = 2;
    localparam int PDATA_W  = 32;

    localparam logic REG_META_INTERVAL = 1'b0;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd8192;
    localparam logic [DATA_W-1:0]     NUL_BYTE       = 8'h00;

    localparam logic [KIND_W-1:0] KIND_AUDIO  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LENGTH = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd4;

    typedef enum logic [1:0] {
        PH_AUDIO  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_META   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [INTERVAL_W-1:0]   audio_count;
        logic [LEN_W-1:0]        meta_remaining;
        logic [LEN_W-1:0]        meta_total;
        logic                    null_seen;
        logic                    text_present;
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] byte_value;
        logic [KIND_W-1:0] byte_kind;
        logic              block_last;
        logic              block_has_text;
        logic [LEN_W-1:0]  block_length;
    } result_t;

endpackage

// ===== hw/rtl/icy_in_if.sv =====
// Input byte channel: valid/ready handshake with one raw stream byte.
interface icy_in_if;
    import icy_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/icy_out_if.sv =====
// Output channel: valid/ready handshake with one tagged byte.
interface icy_out_if;
    import icy_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] byte_value;
    logic [KIND_W-1:0] byte_kind;
    logic              block_last;
    logic              block_has_text;
    logic [LEN_W-1:0]  block_length;

    modport source (output valid, output byte_value, output byte_kind,
                    output block_last, output block_has_text, output block_length,
                    input ready);
    modport sink   (input valid, input byte_value, input byte_kind,
                    input block_last, input block_has_text, input block_length,
                    output ready);
endinterface

// ===== hw/rtl/icy_cfg.sv =====
// APB register block holding the metadata interval.
module icy_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [icy_pkg::PADDR_W-1:0]   paddr,
    input  logic [icy_pkg::PDATA_W-1:0]   pwdata,
    output logic [icy_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [icy_pkg::INTERVAL_W-1:0] meta_interval
);
    import icy_pkg::*;

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  hit_interval;
    logic                  wr_en;

    assign pready       = 1'b1;
    assign hit_interval = (paddr[ADDR_LSB] == REG_META_INTERVAL);
    assign wr_en        = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else if (wr_en && hit_interval)
        begin
            interval_reg <= pwdata[INTERVAL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit_interval)
        begin
            prdata = {{(PDATA_W-INTERVAL_W){1'b0}}, interval_reg};
        end
    end

    assign meta_interval = interval_reg;

endmodule

// ===== hw/rtl/icy_classify.sv =====
// Per-byte tagging and next-state logic of the deframer.
module icy_classify (
    input  icy_pkg::state_t                 state,
    input  logic [icy_pkg::DATA_W-1:0]      data_byte,
    input  logic [icy_pkg::INTERVAL_W-1:0]  meta_interval,
    output icy_pkg::state_t                 state_next,
    output icy_pkg::result_t                result
);
    import icy_pkg::*;

    logic [LEN_W-1:0]      len_bytes;
    logic [LEN_W-1:0]      rem_dec;
    logic [INTERVAL_W-1:0] count_inc;
    logic                  is_nul;
    logic                  text_next;
    logic                  null_next;

    // Length byte times 16, kept to 12 bits.
    assign len_bytes = {data_byte, {UNIT_SHIFT{1'b0}}};
    assign rem_dec   = (state.meta_remaining != '0) ? state.meta_remaining - 1'b1 : '0;
    assign count_inc = state.audio_count + 1'b1;
    assign is_nul    = (data_byte == NUL_BYTE);
    assign text_next = (state.meta_remaining == state.meta_total) ? !is_nul
                                                                   : state.text_present;
    assign null_next = state.null_seen || is_nul;

    always_comb
    begin
        state_next            = state;
        result.byte_value     = data_byte;
        result.byte_kind      = KIND_AUDIO;
        result.block_last     = 1'b0;
        result.block_has_text = 1'b0;
        result.block_length   = '0;

        if (meta_interval == '0)
        begin
            result.byte_kind = KIND_REJECT;
            state_next       = '{PH_AUDIO, '0, '0, '0, 1'b0, 1'b0};
        end
        else
        begin
            case (state.phase)
                PH_LENGTH:
                begin
                    result.byte_kind       = KIND_LENGTH;
                    result.block_length    = len_bytes;
                    state_next.audio_count = '0;
                    if (len_bytes == '0)
                    begin
                        state_next.phase = PH_AUDIO;
                    end
                    else
                    begin
                        state_next.meta_total     = len_bytes;
                        state_next.meta_remaining = len_bytes;
                        state_next.null_seen      = 1'b0;
                        state_next.text_present   = 1'b0;
                        state_next.phase          = PH_META;
                    end
                end
                PH_META:
                begin
                    state_next.text_present   = text_next;
                    state_next.null_seen      = null_next;
                    state_next.meta_remaining = rem_dec;
                    result.byte_kind          = null_next ? KIND_PAD : KIND_TEXT;
                    result.block_length       = state.meta_total;
                    if (rem_dec == '0)
                    begin
                        result.block_last      = 1'b1;
                        result.block_has_text  = text_next;
                        state_next.phase       = PH_AUDIO;
                        state_next.audio_count = '0;
                    end
                end
                default:
                begin
                    // audio, and the unused phase code
                    state_next.phase = PH_AUDIO;
                    if (count_inc >= meta_interval || count_inc == '0)
                    begin
                        state_next.audio_count = '0;
                        state_next.phase       = PH_LENGTH;
                    end
                    else
                    begin
                        state_next.audio_count = count_inc;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/icy_core.sv =====
// Stream state, result register and handshake of the deframer.
`include "icy_metadata_deframer_defines.svh"

module icy_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [icy_pkg::INTERVAL_W-1:0] meta_interval,
    icy_in_if.sink                         in_ch,
    icy_out_if.source                      out_ch
);
    import icy_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    accept;

    icy_classify u_classify (
        .state         (state_reg),
        .data_byte     (in_ch.data_byte),
        .meta_interval (meta_interval),
        .state_next    (state_next),
        .result        (result_next)
    );

    // Take a new word whenever the result register is empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{PH_AUDIO, '0, '0, '0, 1'b0, 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.byte_value     = result_reg.byte_value;
    assign out_ch.byte_kind      = result_reg.byte_kind;
    assign out_ch.block_last     = result_reg.block_last;
    assign out_ch.block_has_text = result_reg.block_has_text;
    assign out_ch.block_length   = result_reg.block_length;

    `ICY_ASSERT_SAME(a_meta_count_sane, clk, rst_n, state_reg.phase == PH_META, state_reg.meta_remaining != '0 && state_reg.meta_remaining <= state_reg.meta_total)
    `ICY_ASSERT_NEXT(a_reject_clears, clk, rst_n, accept && meta_interval == '0, state_reg.phase == PH_AUDIO && state_reg.audio_count == '0 && out_ch.byte_kind == KIND_REJECT)
    `ICY_ASSERT_SAME(a_last_in_block, clk, rst_n, out_valid_reg && result_reg.block_last, result_reg.byte_kind == KIND_TEXT || result_reg.byte_kind == KIND_PAD)
    `ICY_ASSERT_NEXT(a_length_restarts, clk, rst_n, accept && meta_interval != '0 && state_reg.phase == PH_LENGTH, state_reg.audio_count == '0 && out_ch.byte_kind == KIND_LENGTH)

endmodule

// ===== hw/rtl/icy_metadata_deframer.sv =====
// ICY metadata deframer: tags an internet-radio byte stream as audio, length
// byte, metadata text or padding, one byte per clock unless stalled. Each
// accepted word is output in the next cycle from a single result register;
// the input stays ready while that register is empty or being drained, so
// a steady stream with a ready sink runs at one word per cycle. Only the
// stream counters sit between input and result register. meta_interval is
// set through the APB port at byte address 0 and must be written while the
// block is idle; zero makes every byte come out as rejected.
module icy_metadata_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    icy_in_if.sink                        in_ch,
    icy_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [icy_pkg::PADDR_W-1:0]   paddr,
    input  logic [icy_pkg::PDATA_W-1:0]   pwdata,
    output logic [icy_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import icy_pkg::*;

    logic [INTERVAL_W-1:0] meta_interval;

    icy_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .meta_interval (meta_interval)
    );

    icy_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .meta_interval (meta_interval),
        .in_ch         (in_ch),
        .out_ch        (out_ch)
    );

endmodule

// ===== tb/icy_metadata_deframer_test.sv =====
// Self-checking testbench for the ICY metadata deframer: byte tagging, framing and APB setup.
module icy_metadata_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import icy_pkg::*;

    localparam int  RANDOM_ITEMS = 1020;
    localparam int  CALM_ITEMS   = 150;   // tail of the run with no random stall bursts
    localparam int  SETTLE       = 4;     // block latency plus margin before a register write
    localparam int  HOLD_CYCLES  = 200;
    localparam int  REG_UNUSED   = 1;
    localparam real RUN_LIMIT    = 5_000_000.0;

    // Tracks the stream position and queues the tagged words the block owes.
    class stream_scoreboard;
        logic [INTERVAL_W-1:0] interval;
        phase_t                phase;
        logic [INTERVAL_W-1:0] audio_count;
        logic [LEN_W-1:0]      meta_left;
        logic [LEN_W-1:0]      meta_size;
        logic                  zero_seen;
        logic                  first_nonzero;
        result_t               tagged_due[$];
        int                    mismatches;

        function new();
            interval   = INTERVAL_RESET;
            mismatches = 0;
            restart_stream();
        endfunction

        function void restart_stream();
            phase         = PH_AUDIO;
            audio_count   = '0;
            meta_left     = '0;
            meta_size     = '0;
            zero_seen     = 1'b0;
            first_nonzero = 1'b0;
        endfunction

        function void note_byte(logic [DATA_W-1:0] b);
            result_t r;
            r            = '0;
            r.byte_value = b;
            r.byte_kind  = KIND_AUDIO;
            if (interval == '0)
            begin
                r.byte_kind = KIND_REJECT;
                restart_stream();
            end
            else if (phase == PH_LENGTH)
            begin
                r.byte_kind    = KIND_LENGTH;
                r.block_length = {b, 4'b0000};
                audio_count    = '0;
                if (b == NUL_BYTE)
                    phase = PH_AUDIO;
                else
                begin
                    meta_size     = {b, 4'b0000};
                    meta_left     = meta_size;
                    zero_seen     = 1'b0;
                    first_nonzero = 1'b0;
                    phase         = PH_META;
                end
            end
            else if (phase == PH_META)
            begin
                if (meta_left == meta_size)
                    first_nonzero = (b != NUL_BYTE);
                if (b == NUL_BYTE)
                    zero_seen = 1'b1;
                r.byte_kind    = zero_seen ? KIND_PAD : KIND_TEXT;
                r.block_length = meta_size;
                if (meta_left != '0)
                    meta_left--;
                if (meta_left == '0)
                begin
                    r.block_last     = 1'b1;
                    r.block_has_text = first_nonzero;
                    phase            = PH_AUDIO;
                    audio_count      = '0;
                end
            end
            else
            begin
                // audio, and the unused phase code, which falls back to audio
                phase = PH_AUDIO;
                audio_count++;
                if (audio_count >= interval || audio_count == '0)
                begin
                    audio_count = '0;
                    phase       = PH_LENGTH;
                end
            end
            tagged_due.push_back(r);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (tagged_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value=%h kind=%0d last=%b text=%b len=%0d",
                             got.byte_value, got.byte_kind, got.block_last,
                             got.block_has_text, got.block_length);
                return;
            end
            want = tagged_due.pop_front();
            if (got.byte_value !== want.byte_value || got.byte_kind !== want.byte_kind ||
                got.block_last !== want.block_last ||
                got.block_has_text !== want.block_has_text ||
                got.block_length !== want.block_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected value=%h kind=%0d last=%b text=%b len=%0d",
                             want.byte_value, want.byte_kind, want.block_last,
                             want.block_has_text, want.block_length,
                             " got value=%h kind=%0d last=%b text=%b len=%0d",
                             got.byte_value, got.byte_kind, got.block_last,
                             got.block_has_text, got.block_length);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    icy_in_if  in_ch ();
    icy_out_if out_ch ();

    stream_scoreboard sb;
    int  sent;
    bit  calm;
    bit  tx_choppy;
    bit  rx_choppy;
    bit  long_hold;

    icy_metadata_deframer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin : watch
        result_t seen;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_byte(in_ch.data_byte);
            if (out_ch.valid && out_ch.ready)
            begin
                seen.byte_value     = out_ch.byte_value;
                seen.byte_kind      = out_ch.byte_kind;
                seen.block_last     = out_ch.block_last;
                seen.block_has_text = out_ch.block_has_text;
                seen.block_length   = out_ch.block_length;
                sb.check_word(seen);
            end
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!calm && rx_choppy && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [DATA_W-1:0] b);
        if (!calm && tx_choppy && $urandom_range(0, 9) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.tagged_due.size() != 0);
    endtask

    task automatic set_register(input int idx, input logic [PDATA_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx << ADDR_LSB);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == int'(REG_META_INTERVAL))
            sb.interval = value[INTERVAL_W-1:0];
    endtask

    // One audio run, its length byte, then the metadata block.
    task automatic send_frame(input int audio_len, input logic [DATA_W-1:0] units);
        int blk;
        int zero_at;
        repeat (audio_len) push_byte(DATA_W'($urandom_range(0, 255)));
        push_byte(units);
        blk = int'(units) * 16;
        case ($urandom_range(0, 3))
            0:       zero_at = 0;
            1:       zero_at = blk;
            default: zero_at = (blk > 1) ? $urandom_range(1, blk - 1) : 0;
        endcase
        for (int i = 0; i < blk; i++)
        begin
            if (i < zero_at)
                push_byte(DATA_W'($urandom_range(1, 255)));
            else if (i == zero_at)
                push_byte(NUL_BYTE);
            else
                push_byte(DATA_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int  base;
        int  seg;
        int  iv;
        int  frames;
        bit  dirty;
        logic [DATA_W-1:0] units;

        sb              = new();
        sent            = 0;
        calm            = 1'b0;
        tx_choppy       = 1'b0;
        rx_choppy       = 1'b0;
        long_hold       = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        out_ch.ready    = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        push_byte(8'hFF);                           // audio under reset interval
        set_register(int'(REG_META_INTERVAL), 32'd1);
        push_byte(8'h00);                           // count already past interval
        push_byte(8'h01);                           // 16-byte block
        push_byte(8'h49);
        push_byte(8'h63);
        push_byte(NUL_BYTE);                        // padding starts here
        repeat (12) push_byte(DATA_W'($urandom_range(0, 255)));
        push_byte(8'hFF);                           // nonzero padding, last of block
        push_byte(8'h80);
        push_byte(8'h00);                           // empty block
        set_register(REG_UNUSED, 32'hFFFF_FFFF);    // no such register
        push_byte(8'h55);
        push_byte(8'hFF);                           // largest block
        push_byte(NUL_BYTE);                        // block without text
        push_byte(8'h41);
        set_register(int'(REG_META_INTERVAL), 32'd0);
        push_byte(8'hAA);                           // rejected, stream cleared
        set_register(int'(REG_META_INTERVAL), 32'hFFFF_FFFF);
        push_byte(8'h7E);
        push_byte(8'h3C);
        dirty = 1'b1;

        // random part: mostly whole frames, sometimes broken by stray bytes
        base = sent;
        seg  = 0;
        while (sent - base < RANDOM_ITEMS)
        begin
            calm      = (sent - base) > (RANDOM_ITEMS - CALM_ITEMS);
            tx_choppy = $urandom_range(0, 3) != 0;
            rx_choppy = $urandom_range(0, 3) != 0;
            if (dirty)
            begin
                // resync by a rejected stretch
                set_register(int'(REG_META_INTERVAL), 32'd0);
                repeat ($urandom_range(1, 3)) push_byte(DATA_W'($urandom_range(0, 255)));
                dirty = 1'b0;
            end
            case ($urandom_range(0, 19))
                0:       iv = 0;
                1, 2:    iv = $urandom_range(13, 300);
                default: iv = $urandom_range(1, 12);
            endcase
            set_register(int'(REG_META_INTERVAL),
                         {16'($urandom_range(0, 65535)), 16'(iv)});
            if (seg == 2)
                long_hold = 1'b1;
            if (iv == 0)
                repeat ($urandom_range(1, 6)) push_byte(DATA_W'($urandom_range(0, 255)));
            else
            begin
                frames = (iv > 12) ? 1 : $urandom_range(1, 4);
                for (int f = 0; f < frames; f++)
                begin
                    units = ($urandom_range(0, 9) < 7) ? DATA_W'($urandom_range(0, 2))
                                                       : DATA_W'($urandom_range(3, 8));
                    send_frame(iv, units);
                    if (seg == 4 && f == 0)
                        wait_drained();
                end
                if (!calm && $urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 20)) push_byte(DATA_W'($urandom_range(0, 255)));
                    dirty = 1'b1;
                end
            end
            seg++;
        end

        wait_drained();
        repeat (SETTLE * 4) @(posedge clk);
        if (sb.mismatches == 0 && sb.tagged_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== icy_metadata_deframer.f =====
+incdir+hw/rtl
hw/rtl/icy_pkg.sv
hw/rtl/icy_in_if.sv
hw/rtl/icy_out_if.sv
hw/rtl/icy_cfg.sv
hw/rtl/icy_classify.sv
hw/rtl/icy_core.sv
hw/rtl/icy_metadata_deframer.sv
tb/icy_metadata_deframer_test.sv
